@@ rtl/core/mre_pkg.sv @@
// Shared types, codes and helper functions for the mouse report encoder.
`timescale 1ns / 1ps
package mre_pkg;

	localparam int CELL_BITS_DEF  = 12;
	localparam int PIXEL_BITS_DEF = 15;
	localparam int QUEUE_DEPTH    = 2;
	localparam int ADDR_W         = 4;
	localparam int CODE_BITS      = 7;

	// event kinds
	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_MOVE    = 2'd2;

	// buttons
	localparam logic [2:0] BTN_MIDDLE     = 3'd1;
	localparam logic [2:0] BTN_RIGHT      = 3'd2;
	localparam logic [2:0] BTN_WHEEL_UP   = 3'd3;
	localparam logic [2:0] BTN_WHEEL_DOWN = 3'd4;

	// report modes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_PRESS  = 2'd1;
	localparam logic [1:0] MODE_BUTTON = 2'd2;
	localparam logic [1:0] MODE_ANY    = 2'd3;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SGR   = 2'd1;
	localparam logic [1:0] REG_PIXEL = 2'd2;

	localparam logic [7:0] LEGACY_LIMIT  = 8'd223;
	localparam logic [7:0] LEGACY_OFFSET = 8'd32;
	localparam logic [CODE_BITS-1:0] MOTION_BIT = 7'd32;
	localparam logic [1:0] NO_BUTTON = 2'd3;

	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_UPPER_M = 8'h4d;
	localparam logic [7:0] CH_LOWER_M = 8'h6d;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef struct packed {
		logic                 sgr;
		logic                 press;
		logic [CODE_BITS-1:0] code;
		logic [3:0]           code_tens;
		logic [3:0]           code_ones;
	} mre_cmd_t;

	// decimal digits needed for an unsigned value of the given width
	function automatic int dec_digits(input int bits);
		int v;
		int n;
		v = (1 << bits) - 1;
		n = 1;
		for (int i = 0; i < 10; i++) begin
			if (v >= 10) begin
				v = v / 10;
				n = n + 1;
			end
		end
		return n;
	endfunction

	function automatic logic [CODE_BITS-1:0] code_of(input logic [2:0] button);
		logic [CODE_BITS-1:0] c;
		unique case (button)
			BTN_MIDDLE:     c = 7'd1;
			BTN_RIGHT:      c = 7'd2;
			BTN_WHEEL_UP:   c = 7'd64;
			BTN_WHEEL_DOWN: c = 7'd65;
			default:        c = 7'd0;
		endcase
		return c;
	endfunction

	// tens and ones of a code below 100
	function automatic logic [7:0] code_digits(input logic [CODE_BITS-1:0] code);
		logic [3:0]           tens;
		logic [CODE_BITS-1:0] rem;
		tens = 4'd0;
		for (int t = 1; t < 10; t++) begin
			if (code >= 7'(t * 10))
				tens = 4'(t);
		end
		rem = code - 7'(tens) * 7'd10;
		return {tens, rem[3:0]};
	endfunction

endpackage

@@ rtl/core/mre_front.sv @@
// Event classifier: tracks button and selection state and queues report commands.
`timescale 1ns / 1ps
module mre_front #(
	parameter int CELL_BITS  = mre_pkg::CELL_BITS_DEF,
	parameter int PIXEL_BITS = mre_pkg::PIXEL_BITS_DEF,
	parameter int VAL_BITS   = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            opcode,
	input  logic [2:0]            button,
	input  logic [CELL_BITS-1:0]  cell_x,
	input  logic [CELL_BITS-1:0]  cell_y,
	input  logic [PIXEL_BITS-1:0] pixel_x,
	input  logic [PIXEL_BITS-1:0] pixel_y,
	input  logic                  pixel_valid,
	input  logic                  shift_held,
	input  logic                  alt_held,
	input  logic                  ctrl_held,
	input  logic [1:0]            report_mode,
	input  logic                  sgr_enable,
	input  logic                  sgr_pixel_enable,
	input  logic                  cmd_space,
	output logic                  cmd_valid,
	output mre_pkg::mre_cmd_t     cmd,
	output logic [VAL_BITS-1:0]   cmd_x,
	output logic [VAL_BITS-1:0]   cmd_y
);
	import mre_pkg::*;

	logic [1:0]           held_code_q;
	logic                 held_valid_q;
	logic [CELL_BITS-1:0] last_col_q;
	logic [CELL_BITS-1:0] last_row_q;
	logic                 last_valid_q;
	logic                 pending_q;
	logic                 selecting_q;

	logic [1:0]           held_code_d;
	logic                 held_valid_d;
	logic [CELL_BITS-1:0] last_col_d;
	logic [CELL_BITS-1:0] last_row_d;
	logic                 last_valid_d;
	logic                 pending_d;
	logic                 selecting_d;

	logic                 accept;
	logic                 report;
	logic                 press;
	logic [CODE_BITS-1:0] code;
	logic [CODE_BITS-1:0] btn_code;
	logic [CODE_BITS-1:0] mods;
	logic                 is_wheel;
	logic                 use_pix;
	logic                 sgr;
	logic                 overflow;
	logic [7:0]           digits;

	assign in_ready = cmd_space;
	assign accept   = in_valid && cmd_space;
	assign btn_code = code_of(button);
	assign mods     = {2'b00, ctrl_held, alt_held, shift_held, 2'b00};
	assign is_wheel = (button == BTN_WHEEL_UP) || (button == BTN_WHEEL_DOWN);

	always_comb begin
		held_code_d  = held_code_q;
		held_valid_d = held_valid_q;
		last_col_d   = last_col_q;
		last_row_d   = last_row_q;
		last_valid_d = last_valid_q;
		pending_d    = pending_q;
		selecting_d  = selecting_q;
		report       = 1'b0;
		press        = 1'b1;
		code         = '0;
		unique case (opcode)
			OP_PRESS: begin
				if (!shift_held && report_mode != MODE_OFF) begin
					report = 1'b1;
					code   = btn_code + mods;
					if (!is_wheel) begin
						held_code_d  = btn_code[1:0];
						held_valid_d = 1'b1;
						last_col_d   = cell_x;
						last_row_d   = cell_y;
						last_valid_d = 1'b1;
					end
				end else begin
					selecting_d = 1'b0;
					pending_d   = 1'b1;
				end
			end
			OP_RELEASE: begin
				pending_d = 1'b0;
				if (selecting_q) begin
					selecting_d = 1'b0;
				end else if (report_mode != MODE_OFF && held_valid_q) begin
					report = 1'b1;
					press  = 1'b0;
					code   = ((sgr_enable || sgr_pixel_enable) ? btn_code
						: {5'b0, NO_BUTTON}) + mods;
					held_valid_d = 1'b0;
					last_valid_d = 1'b0;
				end
			end
			OP_MOVE: begin
				if (pending_q) begin
					pending_d   = 1'b0;
					selecting_d = 1'b1;
				end
				// a pending selection turns active and swallows the move
				if (!(pending_q || selecting_q)
						&& !(last_valid_q && cell_x == last_col_q && cell_y == last_row_q)
						&& (report_mode == MODE_ANY
							|| (report_mode == MODE_BUTTON && held_valid_q))) begin
					report = 1'b1;
					code   = {5'b0, held_valid_q ? held_code_q : NO_BUTTON} + MOTION_BIT + mods;
					last_col_d   = cell_x;
					last_row_d   = cell_y;
					last_valid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign use_pix  = sgr_pixel_enable && pixel_valid;
	assign sgr      = use_pix || sgr_enable;
	assign overflow = (cell_x >= CELL_BITS'(LEGACY_LIMIT)) || (cell_y >= CELL_BITS'(LEGACY_LIMIT));
	assign digits   = code_digits(code);

	// state still updates when a legacy report is out of range
	assign cmd_valid     = accept && report && (sgr || !overflow);
	assign cmd.sgr       = sgr;
	assign cmd.press     = press;
	assign cmd.code      = code;
	assign cmd.code_tens = digits[7:4];
	assign cmd.code_ones = digits[3:0];
	assign cmd_x = use_pix ? VAL_BITS'(pixel_x) + VAL_BITS'(1) : VAL_BITS'(cell_x) + VAL_BITS'(1);
	assign cmd_y = use_pix ? VAL_BITS'(pixel_y) + VAL_BITS'(1) : VAL_BITS'(cell_y) + VAL_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_code_q  <= '0;
			held_valid_q <= 1'b0;
			last_col_q   <= '0;
			last_row_q   <= '0;
			last_valid_q <= 1'b0;
			pending_q    <= 1'b0;
			selecting_q  <= 1'b0;
		end else if (accept) begin
			held_code_q  <= held_code_d;
			held_valid_q <= held_valid_d;
			last_col_q   <= last_col_d;
			last_row_q   <= last_row_d;
			last_valid_q <= last_valid_d;
			pending_q    <= pending_d;
			selecting_q  <= selecting_d;
		end
	end

endmodule

@@ rtl/core/mre_fifo.sv @@
// Small command queue between the classifier and the byte serializer.
`timescale 1ns / 1ps
module mre_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = mre_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             space,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign space    = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

@@ rtl/core/mre_back.sv @@
// Byte serializer: SGR coordinates to decimal, one byte per cycle unless stalled.
`timescale 1ns / 1ps
module mre_back #(
	parameter int VAL_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  mre_pkg::mre_cmd_t   cmd,
	input  logic [VAL_BITS-1:0] cmd_x,
	input  logic [VAL_BITS-1:0] cmd_y,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // out_byte
	output logic                m_tlast   // last_byte
);
	import mre_pkg::*;

	localparam int NCONV      = (VAL_BITS + 3) / 4;
	localparam int CONV_BITS  = NCONV * 4;
	localparam int DEC_DIGITS = dec_digits(VAL_BITS);
	localparam int BCD_W      = DEC_DIGITS * 4;
	localparam int DIG_W      = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
	localparam int CNT_W      = $clog2(NCONV + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ESC   = 4'd1;
	localparam logic [3:0] ST_BRK   = 4'd2;
	localparam logic [3:0] ST_LEAD  = 4'd3;
	localparam logic [3:0] ST_CODE  = 4'd4;
	localparam logic [3:0] ST_SEMI1 = 4'd5;
	localparam logic [3:0] ST_XDIG  = 4'd6;
	localparam logic [3:0] ST_SEMI2 = 4'd7;
	localparam logic [3:0] ST_YDIG  = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_LCB   = 4'd10;
	localparam logic [3:0] ST_LCX   = 4'd11;
	localparam logic [3:0] ST_LCY   = 4'd12;

	logic [3:0]           state_q, state_d;
	logic [DIG_W-1:0]     dig_q, dig_d;
	logic [CNT_W-1:0]     conv_cnt_q;
	mre_cmd_t             ctl_q;
	logic [CONV_BITS-1:0] xbin_q, ybin_q;
	logic [BCD_W-1:0]     xbcd_q, ybcd_q;
	logic                 out_valid_q;
	logic [7:0]           out_data_q;
	logic                 out_last_q;

	logic                 slot_free;
	logic                 emit;
	logic                 load;
	logic [7:0]           byte_d;
	logic                 last_d;
	logic [DIG_W-1:0]     xtop, ytop;
	logic [3:0]           xdigit, ydigit, cdigit;
	logic [BCD_W+CONV_BITS-1:0] xstep, ystep;

	// four double-dabble steps: add-3 correction then shift in the next bit
	function automatic logic [BCD_W+CONV_BITS-1:0] dd4(input logic [BCD_W-1:0] bcd_in,
			input logic [CONV_BITS-1:0] bin_in);
		logic [BCD_W-1:0]     b;
		logic [CONV_BITS-1:0] v;
		b = bcd_in;
		v = bin_in;
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < DEC_DIGITS; d++) begin
				if (b[d*4 +: 4] >= 4'd5)
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
			end
			b = {b[BCD_W-2:0], v[CONV_BITS-1]};
			v = {v[CONV_BITS-2:0], 1'b0};
		end
		return {b, v};
	endfunction

	assign xstep = dd4(xbcd_q, xbin_q);
	assign ystep = dd4(ybcd_q, ybin_q);

	// highest nonzero digit, leading zeros are not sent
	always_comb begin
		xtop = '0;
		ytop = '0;
		for (int d = 0; d < DEC_DIGITS; d++) begin
			if (xbcd_q[d*4 +: 4] != 4'd0)
				xtop = DIG_W'(d);
			if (ybcd_q[d*4 +: 4] != 4'd0)
				ytop = DIG_W'(d);
		end
	end

	assign xdigit = xbcd_q[{dig_q, 2'b00} +: 4];
	assign ydigit = ybcd_q[{dig_q, 2'b00} +: 4];
	assign cdigit = (dig_q != '0) ? ctl_q.code_tens : ctl_q.code_ones;

	assign slot_free = !out_valid_q || m_tready;
	assign cmd_pop   = load;

	always_comb begin
		state_d = state_q;
		dig_d   = dig_q;
		load    = 1'b0;
		emit    = 1'b0;
		byte_d  = CH_ESC;
		last_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					load    = 1'b1;
					state_d = ST_ESC;
				end
			end
			ST_ESC: begin
				byte_d = CH_ESC;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_BRK;
				end
			end
			ST_BRK: begin
				byte_d = CH_LBRACK;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_LEAD;
				end
			end
			ST_LEAD: begin
				byte_d = ctl_q.sgr ? CH_LT : CH_UPPER_M;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ctl_q.sgr ? ST_CODE : ST_LCB;
					dig_d   = (ctl_q.code_tens != 4'd0) ? DIG_W'(1) : '0;
				end
			end
			ST_CODE: begin
				byte_d = CH_ZERO + {4'b0, cdigit};
				if (slot_free) begin
					emit = 1'b1;
					if (dig_q == '0)
						state_d = ST_SEMI1;
					else
						dig_d = dig_q - DIG_W'(1);
				end
			end
			ST_SEMI1: begin
				byte_d = CH_SEMI;
				// digits are needed next, wait for the conversion to finish
				if (slot_free && conv_cnt_q == '0) begin
					emit    = 1'b1;
					state_d = ST_XDIG;
					dig_d   = xtop;
				end
			end
			ST_XDIG: begin
				byte_d = CH_ZERO + {4'b0, xdigit};
				if (slot_free) begin
					emit = 1'b1;
					if (dig_q == '0)
						state_d = ST_SEMI2;
					else
						dig_d = dig_q - DIG_W'(1);
				end
			end
			ST_SEMI2: begin
				byte_d = CH_SEMI;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_YDIG;
					dig_d   = ytop;
				end
			end
			ST_YDIG: begin
				byte_d = CH_ZERO + {4'b0, ydigit};
				if (slot_free) begin
					emit = 1'b1;
					if (dig_q == '0)
						state_d = ST_FIN;
					else
						dig_d = dig_q - DIG_W'(1);
				end
			end
			ST_FIN: begin
				byte_d = ctl_q.press ? CH_UPPER_M : CH_LOWER_M;
				last_d = 1'b1;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_LCB: begin
				byte_d = {1'b0, ctl_q.code} + LEGACY_OFFSET;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_LCX;
				end
			end
			ST_LCX: begin
				byte_d = xbin_q[7:0] + LEGACY_OFFSET;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_LCY;
				end
			end
			ST_LCY: begin
				byte_d = ybin_q[7:0] + LEGACY_OFFSET;
				last_d = 1'b1;
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dig_q       <= '0;
			conv_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dig_q   <= dig_d;
			if (load)
				conv_cnt_q <= cmd.sgr ? CNT_W'(NCONV) : '0;
			else if (conv_cnt_q != '0)
				conv_cnt_q <= conv_cnt_q - CNT_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_q  <= cmd;
			xbin_q <= CONV_BITS'(cmd_x);
			ybin_q <= CONV_BITS'(cmd_y);
			xbcd_q <= '0;
			ybcd_q <= '0;
		end else if (conv_cnt_q != '0) begin
			{xbcd_q, xbin_q} <= xstep;
			{ybcd_q, ybin_q} <= ystep;
		end
		if (emit) begin
			out_data_q <= byte_d;
			out_last_q <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XDIG || state_q == ST_YDIG) |-> conv_cnt_q == '0)
		else $error("coordinate digits used before conversion finished");

	a_digit_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XDIG) |-> xdigit <= 4'd9)
		else $error("x digit out of decimal range");

	a_sgr_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CODE || state_q == ST_XDIG || state_q == ST_YDIG) |-> ctl_q.sgr)
		else $error("decimal field sent for a legacy report");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_d) |=> state_q == ST_IDLE)
		else $error("report did not end after its last byte");

endmodule

@@ rtl/core/mouse_report_encoder.sv @@
// Mouse report encoder: press/release/move events in, xterm report bytes out.
// Reports pass the queue, the serializer's load state and its output register.
// Throughput: one byte per cycle unless stalled; reports are 6 bytes legacy or
// up to 18 SGR, each loaded after the previous one ends, with the decimal
// conversion overlapping the prefix bytes. A 2-entry queue decouples the sides.
// Reset: arst_n clears registers, tracking state and queue; no clearing pass.
`timescale 1ns / 1ps
module mouse_report_encoder #(
	parameter int CELL_BITS   = mre_pkg::CELL_BITS_DEF,
	parameter int PIXEL_BITS  = mre_pkg::PIXEL_BITS_DEF,
	parameter int QUEUE_DEPTH = mre_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	// input events
	input  logic s_tvalid,
	output logic s_tready,
	// button, cell_x, cell_y, pixel_x, pixel_y, pixel_valid, shift_held, alt_held,
	// ctrl_held; zero padded to bytes
	input  logic [((3 + 2*CELL_BITS + 2*PIXEL_BITS + 4 + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic [1:0] s_tuser,  // opcode
	// report bytes
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic m_tlast,        // last_byte
	// configuration
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mre_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import mre_pkg::*;

	localparam int VAL_BITS = ((CELL_BITS > PIXEL_BITS) ? CELL_BITS : PIXEL_BITS) + 1;
	localparam int CMD_BITS = $bits(mre_cmd_t);
	localparam int Q_W      = CMD_BITS + 2 * VAL_BITS;
	localparam int OFS_CY   = 3 + CELL_BITS;
	localparam int OFS_PX   = 3 + 2 * CELL_BITS;
	localparam int OFS_PY   = OFS_PX + PIXEL_BITS;
	localparam int OFS_FLG  = OFS_PY + PIXEL_BITS;

	logic [1:0] report_mode_q;
	logic       sgr_enable_q;
	logic       sgr_pixel_enable_q;
	logic       cfg_write;

	logic                front_valid;
	logic                q_space;
	mre_cmd_t            front_cmd;
	logic [VAL_BITS-1:0] front_x, front_y;
	logic                q_valid;
	logic                q_pop;
	logic [Q_W-1:0]      q_rd;
	mre_cmd_t            back_cmd;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_mode_q      <= MODE_OFF;
			sgr_enable_q       <= 1'b0;
			sgr_pixel_enable_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_MODE:  report_mode_q      <= pwdata[1:0];
				REG_SGR:   sgr_enable_q       <= pwdata[0];
				REG_PIXEL: sgr_pixel_enable_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:  prdata = {30'b0, report_mode_q};
			REG_SGR:   prdata = {31'b0, sgr_enable_q};
			REG_PIXEL: prdata = {31'b0, sgr_pixel_enable_q};
			default:   prdata = '0;
		endcase
	end

	mre_front #(
		.CELL_BITS  (CELL_BITS),
		.PIXEL_BITS (PIXEL_BITS),
		.VAL_BITS   (VAL_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.opcode           (s_tuser),
		.button           (s_tdata[2:0]),
		.cell_x           (s_tdata[3 +: CELL_BITS]),
		.cell_y           (s_tdata[OFS_CY +: CELL_BITS]),
		.pixel_x          (s_tdata[OFS_PX +: PIXEL_BITS]),
		.pixel_y          (s_tdata[OFS_PY +: PIXEL_BITS]),
		.pixel_valid      (s_tdata[OFS_FLG]),
		.shift_held       (s_tdata[OFS_FLG + 1]),
		.alt_held         (s_tdata[OFS_FLG + 2]),
		.ctrl_held        (s_tdata[OFS_FLG + 3]),
		.report_mode      (report_mode_q),
		.sgr_enable       (sgr_enable_q),
		.sgr_pixel_enable (sgr_pixel_enable_q),
		.cmd_space        (q_space),
		.cmd_valid        (front_valid),
		.cmd              (front_cmd),
		.cmd_x            (front_x),
		.cmd_y            (front_y)
	);

	mre_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.wr_data  ({front_cmd, front_x, front_y}),
		.space    (q_space),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd)
	);

	assign back_cmd = q_rd[Q_W-1 -: CMD_BITS];

	mre_back #(
		.VAL_BITS (VAL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (back_cmd),
		.cmd_x     (q_rd[VAL_BITS +: VAL_BITS]),
		.cmd_y     (q_rd[VAL_BITS-1:0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for mouse_report_encoder: event stream in, report bytes checked.
`timescale 1ns / 1ps
module tb;
	import mre_pkg::*;

	localparam int CELL_W  = CELL_BITS_DEF;
	localparam int PIXEL_W = PIXEL_BITS_DEF;
	localparam int PERIOD_HALF_NS = 6;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int ITEMS_PER_PHASE = 17;
	localparam int NUM_PHASES = 8;
	localparam longint TIMEOUT_NS = 5_000_000;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] BTN_LEFT  = 3'd0;
	localparam logic [2:0] BTN_OTHER = 3'd5;
	localparam logic [2:0] BTN_SPARE = 3'd7;

	localparam int unsigned CODE_MIDDLE     = 1;
	localparam int unsigned CODE_RIGHT      = 2;
	localparam int unsigned CODE_WHEEL_UP   = 64;
	localparam int unsigned CODE_WHEEL_DOWN = 65;
	localparam int unsigned MOD_SHIFT = 4;
	localparam int unsigned MOD_ALT   = 8;
	localparam int unsigned MOD_CTRL  = 16;

	// matches the s_tdata layout, lowest field last
	typedef struct packed {
		logic [2:0]         pad;
		logic               ctrl;
		logic               alt;
		logic               shift;
		logic               pvalid;
		logic [PIXEL_W-1:0] py;
		logic [PIXEL_W-1:0] px;
		logic [CELL_W-1:0]  cy;
		logic [CELL_W-1:0]  cx;
		logic [2:0]         button;
	} mouse_event_t;

	class report_scoreboard;
		logic [1:0]        mode;
		bit                sgr;
		bit                pix;
		logic [1:0]        held_code;
		bit                held_valid;
		logic [CELL_W-1:0] last_col;
		logic [CELL_W-1:0] last_row;
		bit                last_valid;
		bit                pend_sel;
		bit                selecting;
		logic [8:0]        expected_bytes[$];  // {last, byte}
		int                errors;

		function new();
			mode = MODE_OFF;
			sgr = 0;
			pix = 0;
			held_code = '0;
			held_valid = 0;
			last_col = '0;
			last_row = '0;
			last_valid = 0;
			pend_sel = 0;
			selecting = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_MODE:  mode = value[1:0];
				REG_SGR:   sgr = value[0];
				REG_PIXEL: pix = value[0];
				default: ;
			endcase
		endfunction

		function int unsigned button_code(logic [2:0] b);
			case (b)
				BTN_MIDDLE:     return CODE_MIDDLE;
				BTN_RIGHT:      return CODE_RIGHT;
				BTN_WHEEL_UP:   return CODE_WHEEL_UP;
				BTN_WHEEL_DOWN: return CODE_WHEEL_DOWN;
				default:        return 0;
			endcase
		endfunction

		function void push_report(int unsigned cb, bit press, mouse_event_t ev);
			bit          use_pix;
			int unsigned x;
			int unsigned y;
			string       nums;
			logic [7:0]  seq[$];
			use_pix = pix && ev.pvalid;
			if (use_pix || sgr) begin
				x = use_pix ? int'(ev.px) + 1 : int'(ev.cx) + 1;
				y = use_pix ? int'(ev.py) + 1 : int'(ev.cy) + 1;
				nums = $sformatf("%0d;%0d;%0d", cb, x, y);
				seq = {CH_ESC, CH_LBRACK, CH_LT};
				for (int i = 0; i < nums.len(); i++)
					seq.push_back(nums[i]);
				seq.push_back(press ? CH_UPPER_M : CH_LOWER_M);
			end else begin
				x = int'(ev.cx) + 1;
				y = int'(ev.cy) + 1;
				// legacy coordinates past the limit give no report at all
				if (x > LEGACY_LIMIT || y > LEGACY_LIMIT)
					return;
				seq = {CH_ESC, CH_LBRACK, CH_UPPER_M, 8'(cb + LEGACY_OFFSET),
					8'(x + LEGACY_OFFSET), 8'(y + LEGACY_OFFSET)};
			end
			foreach (seq[i])
				expected_bytes.push_back({i == seq.size() - 1, seq[i]});
		endfunction

		function void note_event(logic [1:0] op, mouse_event_t ev);
			int unsigned mods;
			int unsigned code;
			mods = (ev.shift ? MOD_SHIFT : 0) + (ev.alt ? MOD_ALT : 0) + (ev.ctrl ? MOD_CTRL : 0);
			case (op)
				OP_PRESS: begin
					if (!ev.shift && mode != MODE_OFF) begin
						code = button_code(ev.button);
						if (ev.button != BTN_WHEEL_UP && ev.button != BTN_WHEEL_DOWN) begin
							held_code = code[1:0];
							held_valid = 1;
							last_col = ev.cx;
							last_row = ev.cy;
							last_valid = 1;
						end
						push_report(code + mods, 1, ev);
					end else begin
						selecting = 0;
						pend_sel = 1;
					end
				end
				OP_RELEASE: begin
					pend_sel = 0;
					if (selecting) begin
						selecting = 0;
					end else if (mode != MODE_OFF && held_valid) begin
						code = (sgr || pix) ? button_code(ev.button) : int'(NO_BUTTON);
						push_report(code + mods, 0, ev);
						held_valid = 0;
						last_valid = 0;
					end
				end
				OP_MOVE: begin
					if (pend_sel) begin
						pend_sel = 0;
						selecting = 1;
					end
					if (!selecting && !(last_valid && ev.cx == last_col && ev.cy == last_row) &&
						(mode == MODE_ANY || (mode == MODE_BUTTON && held_valid))) begin
						code = held_valid ? int'(held_code) : int'(NO_BUTTON);
						push_report(code + int'(MOTION_BIT) + mods, 1, ev);
						last_col = ev.cx;
						last_row = ev.cy;
						last_valid = 1;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_byte(logic [7:0] data, logic last);
			logic [8:0] want;
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte: expected none, actual %h last %b", $time, data, last);
				return;
			end
			want = expected_bytes.pop_front();
			if (want[7:0] !== data) begin
				errors++;
				$display("%0t: out_byte mismatch: expected %h, actual %h", $time, want[7:0], data);
			end
			if (want[8] !== last) begin
				errors++;
				$display("%0t: last_byte mismatch: expected %b, actual %b", $time, want[8], last);
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // button, cell_x, cell_y, pixel_x, pixel_y, pixel_valid, shift, alt, ctrl
	logic [1:0]  s_tuser = '0;  // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // out_byte
	logic        m_tlast;       // last_byte
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	report_scoreboard sb = new();
	bit quiet = 0;
	bit long_hold_req = 0;
	int ready_stall = 0;
	int events_sent = 0;

	mouse_report_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#PERIOD_HALF_NS clk = 1'b1;
		#PERIOD_HALF_NS clk = 1'b0;
	end

	// output side backpressure
	always @(negedge clk) begin
		if (ready_stall > 0) begin
			m_tready <= 1'b0;
			ready_stall = ready_stall - 1;
		end else if (long_hold_req) begin
			long_hold_req = 0;
			ready_stall = LONG_HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
			ready_stall = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_byte(m_tdata, m_tlast);

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_event(input logic [1:0] op, input mouse_event_t ev);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ev;
		do @(posedge clk); while (!s_tready);
		sb.note_event(op, ev);
		events_sent++;
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// registers change only with nothing in flight
	task automatic configure(input logic [1:0] mode, input bit sgr, input bit pix);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		reg_write(REG_MODE, {30'd0, mode});
		reg_write(REG_SGR, {31'd0, sgr});
		reg_write(REG_PIXEL, {31'd0, pix});
	endtask

	function automatic logic [CELL_W-1:0] pick_cell();
		case ($urandom_range(0, 9))
			0:       return CELL_W'($urandom_range(0, (1 << CELL_W) - 1));
			1:       return CELL_W'($urandom_range(218, 228));  // around the legacy limit
			default: return CELL_W'($urandom_range(0, 230));
		endcase
	endfunction

	function automatic mouse_event_t rand_event();
		mouse_event_t ev;
		ev = {$urandom, $urandom};
		ev.pad = '0;
		ev.cx = pick_cell();
		ev.cy = pick_cell();
		return ev;
	endfunction

	function automatic mouse_event_t next_move(mouse_event_t prev);
		mouse_event_t ev;
		ev = rand_event();
		ev.button = prev.button;
		if ($urandom_range(0, 2) == 0) begin
			ev.cx = prev.cx;
			ev.cy = prev.cy;
		end
		return ev;
	endfunction

	function automatic mouse_event_t at_cell(logic [2:0] b, int cx, int cy);
		mouse_event_t ev;
		ev = '0;
		ev.button = b;
		ev.cx = CELL_W'(cx);
		ev.cy = CELL_W'(cy);
		ev.px = PIXEL_W'(cx * 8 + 3);
		ev.py = PIXEL_W'(cy * 16 + 5);
		ev.pvalid = 1'b1;
		return ev;
	endfunction

	// press, a few drags, release; sometimes shifted so it turns into a selection
	task automatic gesture();
		mouse_event_t ev;
		logic [2:0]   btn;
		int           moves;
		ev = rand_event();
		btn = ev.button;
		ev.shift = ($urandom_range(0, 5) == 0);
		send_event(OP_PRESS, ev);
		moves = $urandom_range(0, 4);
		repeat (moves) begin
			ev = next_move(ev);
			send_event(OP_MOVE, ev);
		end
		ev = next_move(ev);
		ev.button = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : btn;
		send_event(OP_RELEASE, ev);
		if ($urandom_range(0, 1) == 0) begin
			ev = next_move(ev);
			send_event(OP_MOVE, ev);
		end
	endtask

	initial begin
		mouse_event_t ev;
		int           phase_start;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// legacy format, any-event motion
		configure(MODE_ANY, 1'b0, 1'b0);
		send_event(OP_PRESS, at_cell(BTN_LEFT, 0, 0));
		send_event(OP_MOVE, at_cell(BTN_LEFT, 0, 0));     // same cell, dropped
		send_event(OP_MOVE, at_cell(BTN_LEFT, 5, 7));
		send_event(OP_RELEASE, at_cell(BTN_LEFT, 5, 7));
		send_event(OP_MOVE, at_cell(BTN_LEFT, 222, 222)); // nothing held, edge of legacy range
		send_event(OP_MOVE, at_cell(BTN_LEFT, 223, 0));   // past legacy range
		ev = at_cell(BTN_WHEEL_UP, 10, 10);
		ev.alt = 1'b1;
		ev.ctrl = 1'b1;
		send_event(OP_PRESS, ev);
		send_event(OP_PRESS, at_cell(BTN_WHEEL_DOWN, 11, 10));
		send_event(OP_PRESS, at_cell(BTN_SPARE, 1, 1));
		send_event(OP_RELEASE, at_cell(BTN_SPARE, 1, 1));
		ev = at_cell(BTN_LEFT, 2, 2);
		ev.shift = 1'b1;
		send_event(OP_PRESS, ev);                          // arms a selection
		send_event(OP_MOVE, at_cell(BTN_LEFT, 3, 3));
		send_event(OP_MOVE, at_cell(BTN_LEFT, 4, 4));
		send_event(OP_RELEASE, at_cell(BTN_LEFT, 4, 4));
		send_event(OP_UNUSED, at_cell(BTN_OTHER, 9, 9));

		// SGR pixel at the top of every range
		configure(MODE_ANY, 1'b1, 1'b1);
		ev = '1;
		ev.pad = '0;
		ev.button = BTN_RIGHT;
		ev.shift = 1'b0;
		send_event(OP_PRESS, ev);
		ev = '1;
		ev.pad = '0;
		ev.cy = '0;
		ev.pvalid = 1'b0;                                  // falls back to cell coordinates
		send_event(OP_MOVE, ev);
		send_event(OP_RELEASE, at_cell(BTN_RIGHT, 4095, 0));

		// pixel format without SGR, button-event motion
		configure(MODE_BUTTON, 1'b0, 1'b1);
		send_event(OP_MOVE, at_cell(BTN_LEFT, 20, 20));
		ev = at_cell(BTN_MIDDLE, 12, 12);
		ev.pvalid = 1'b0;
		send_event(OP_PRESS, ev);
		send_event(OP_MOVE, at_cell(BTN_MIDDLE, 13, 12));
		send_event(OP_RELEASE, at_cell(BTN_MIDDLE, 13, 12));

		configure(MODE_PRESS, 1'b0, 1'b0);
		send_event(OP_PRESS, at_cell(BTN_OTHER, 30, 40));
		send_event(OP_MOVE, at_cell(BTN_OTHER, 31, 40));
		send_event(OP_RELEASE, at_cell(BTN_OTHER, 31, 40));

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: configure(MODE_ANY, 1'b0, 1'b0);
				1: configure(MODE_ANY, 1'b1, 1'b0);
				2: configure(MODE_BUTTON, 1'b1, 1'b1);
				3: configure(MODE_OFF, 1'b0, 1'b1);
				4: configure(MODE_PRESS, 1'b1, 1'b0);
				5: configure(MODE_ANY, 1'b0, 1'b1);
				default: configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			endcase
			if (p == 1)
				long_hold_req = 1;  // output stalls while events keep coming
			if (p == NUM_PHASES - 1)
				quiet = 1;
			phase_start = events_sent;
			while (events_sent - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 7) begin
					gesture();
				end else begin
					ev = rand_event();
					send_event(2'($urandom_range(0, 3)), ev);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
